// ----- hw/rtl/pdac_pkg.sv -----
// shared constants and control/status types of the packet deframer
package pdac_pkg;

   localparam int MAX_PAYLOAD = 64;
   localparam int PAYLOAD_AW  = $clog2(MAX_PAYLOAD);
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 7;
   localparam int IDX_W       = 6;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_AW      = 3;

   // register indexes of the configuration port
   localparam logic [CSR_AW-3:0] REG_START_BYTE = 1'b0;
   localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hAA;

   // commands from the controller to the datapath
   typedef struct packed {
      logic clr_sum;
      logic ld_cmd;
      logic ld_type;
      logic ld_len;
      logic wr_data;
      logic start_dump;
      logic dump_en;
      logic hdr_load;
   } pdac_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic start_hit;
      logic len_over;
      logic len_zero_in;
      logic data_last;
      logic sum_match;
      logic len_zero_hold;
      logic dump_done;
      logic out_free;
   } pdac_status_type;

endpackage

// ----- hw/rtl/pdac_ram.sv -----
// generic single-write, single-read ram with registered read data
module pdac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/pdac_datapath.sv -----
// header registers, running sum, payload memory and result register
module pdac_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [pdac_pkg::BYTE_W-1:0]           rx_byte,
   input  logic [pdac_pkg::BYTE_W-1:0]           start_byte,
   input  pdac_pkg::pdac_cmd_type                cmd,
   output pdac_pkg::pdac_status_type             status,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [pdac_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);
   import pdac_pkg::*;

   logic [BYTE_W-1:0]     sum_ff, sum_in;
   logic [BYTE_W-1:0]     cmd_ff, cmd_in;
   logic [BYTE_W-1:0]     type_ff, type_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [LEN_W-1:0]      wr_idx_ff, wr_idx_in;
   logic [LEN_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic                  pend_ff, pend_in;
   logic [BYTE_W-1:0]     ram_rdata;
   logic                  issue, move, out_free, hdr_take;

   logic                  out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]     o_cmd_ff, o_cmd_in;
   logic [BYTE_W-1:0]     o_type_ff, o_type_in;
   logic [LEN_W-1:0]      o_len_ff, o_len_in;
   logic [BYTE_W-1:0]     o_data_ff, o_data_in;
   logic [IDX_W-1:0]      o_idx_ff, o_idx_in;
   logic                  o_has_ff, o_has_in;
   logic                  o_last_ff, o_last_in;

   assign out_free = !out_valid_ff || rsp_tready;
   assign move     = pend_ff && out_free;
   assign issue    = cmd.dump_en && (rd_cnt_ff < len_ff) && (!pend_ff || move);
   assign hdr_take = cmd.hdr_load && out_free;

   always_comb begin
      sum_in    = sum_ff;
      cmd_in    = cmd_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      wr_idx_in = wr_idx_ff;
      if (cmd.clr_sum) begin
         sum_in = '0;
      end
      if (cmd.ld_cmd || cmd.ld_type || cmd.ld_len || cmd.wr_data) begin
         sum_in = sum_ff + rx_byte;
      end
      if (cmd.ld_cmd) begin
         cmd_in = rx_byte;
      end
      if (cmd.ld_type) begin
         type_in = rx_byte;
      end
      if (cmd.ld_len) begin
         len_in    = rx_byte[LEN_W-1:0];
         wr_idx_in = '0;
      end
      if (cmd.wr_data) begin
         wr_idx_in = wr_idx_ff + 1'b1;
      end
   end

   always_comb begin
      rd_cnt_in   = rd_cnt_ff;
      pend_idx_in = pend_idx_ff;
      pend_in     = pend_ff;
      if (cmd.start_dump) begin
         rd_cnt_in = '0;
      end else if (issue) begin
         rd_cnt_in = rd_cnt_ff + 1'b1;
      end
      if (issue) begin
         pend_idx_in = rd_cnt_ff[IDX_W-1:0];
         pend_in     = 1'b1;
      end else if (move) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      o_cmd_in     = o_cmd_ff;
      o_type_in    = o_type_ff;
      o_len_in     = o_len_ff;
      o_data_in    = o_data_ff;
      o_idx_in     = o_idx_ff;
      o_has_in     = o_has_ff;
      o_last_in    = o_last_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (move) begin
         out_valid_in = 1'b1;
         o_cmd_in     = cmd_ff;
         o_type_in    = type_ff;
         o_len_in     = len_ff;
         o_data_in    = ram_rdata;
         o_idx_in     = pend_idx_ff;
         o_has_in     = 1'b1;
         o_last_in    = ({1'b0, pend_idx_ff} + 1'b1) == len_ff;
      end else if (hdr_take) begin
         out_valid_in = 1'b1;
         o_cmd_in     = cmd_ff;
         o_type_in    = type_ff;
         o_len_in     = len_ff;
         o_data_in    = '0;
         o_idx_in     = '0;
         o_has_in     = 1'b0;
         o_last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         cmd_ff       <= '0;
         type_ff      <= '0;
         len_ff       <= '0;
         wr_idx_ff    <= '0;
         rd_cnt_ff    <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         cmd_ff       <= cmd_in;
         type_ff      <= type_in;
         len_ff       <= len_in;
         wr_idx_ff    <= wr_idx_in;
         rd_cnt_ff    <= rd_cnt_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      pend_idx_ff <= pend_idx_in;
      o_cmd_ff    <= o_cmd_in;
      o_type_ff   <= o_type_in;
      o_len_ff    <= o_len_in;
      o_data_ff   <= o_data_in;
      o_idx_ff    <= o_idx_in;
      o_has_ff    <= o_has_in;
      o_last_ff   <= o_last_in;
   end

   pdac_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_data),
      .wr_addr (wr_idx_ff[PAYLOAD_AW-1:0]),
      .wr_data (rx_byte),
      .rd_en   (issue),
      .rd_addr (rd_cnt_ff[PAYLOAD_AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign status.start_hit     = rx_byte == start_byte;
   assign status.len_over      = rx_byte > BYTE_W'(MAX_PAYLOAD);
   assign status.len_zero_in   = rx_byte == '0;
   assign status.data_last     = (wr_idx_ff + 1'b1) >= len_ff;
   assign status.sum_match     = rx_byte == sum_ff;
   assign status.len_zero_hold = len_ff == '0;
   assign status.dump_done     = (rd_cnt_ff == len_ff) && !pend_ff;
   assign status.out_free      = out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, o_idx_ff, o_data_ff, o_len_ff, o_type_ff, o_cmd_ff};
   assign rsp_tuser  = o_has_ff;
   assign rsp_tlast  = o_last_ff;

endmodule

// ----- hw/rtl/pdac_ctrl.sv -----
// framing state machine of the packet deframer
module pdac_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  pdac_pkg::pdac_status_type status,
   output pdac_pkg::pdac_cmd_type    cmd
);
   import pdac_pkg::*;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_CMD,
      ST_TYPE,
      ST_LEN,
      ST_DATA,
      ST_CHECK,
      ST_DUMP,
      ST_HDR
   } state_type;

   state_type state_ff, state_in;
   logic      tready_ff, tready_in;
   logic      accept;

   assign accept = req_tvalid && tready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_HUNT: begin
            if (accept && status.start_hit) begin
               cmd.clr_sum = 1'b1;
               state_in    = ST_CMD;
            end
         end
         ST_CMD: begin
            if (accept) begin
               cmd.ld_cmd = 1'b1;
               state_in   = ST_TYPE;
            end
         end
         ST_TYPE: begin
            if (accept) begin
               cmd.ld_type = 1'b1;
               state_in    = ST_LEN;
            end
         end
         ST_LEN: begin
            if (accept) begin
               cmd.ld_len = 1'b1;
               if (status.len_over) begin
                  state_in = ST_HUNT;
               end else if (status.len_zero_in) begin
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            if (accept) begin
               cmd.wr_data = 1'b1;
               if (status.data_last) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (accept) begin
               if (!status.sum_match) begin
                  state_in = ST_HUNT;
               end else if (status.len_zero_hold) begin
                  state_in = ST_HDR;
               end else begin
                  cmd.start_dump = 1'b1;
                  state_in       = ST_DUMP;
               end
            end
         end
         ST_DUMP: begin
            cmd.dump_en = 1'b1;
            if (status.dump_done) begin
               state_in = ST_HUNT;
            end
         end
         ST_HDR: begin
            cmd.hdr_load = 1'b1;
            if (status.out_free) begin
               state_in = ST_HUNT;
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
      tready_in = (state_in != ST_DUMP) && (state_in != ST_HDR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_HUNT;
         tready_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         tready_ff <= tready_in;
      end
   end

   assign req_tready = tready_ff;

endmodule

// ----- hw/rtl/packet_deframer_add_checksum_core.sv -----
// top level of the start-byte framed packet receiver with additive checksum
//
// takes one received byte per transaction on req_ and hunts for the start byte
// (csr register 0, reset 0xaa); then command, type, length and payload bytes
// are taken one per cycle, and the next byte is compared with the 8-bit
// wrapping sum of everything after the start byte. a good packet comes out
// on rsp_ as one transaction per payload byte (tlast on the final one), or
// as one header-only transaction with tuser low for an empty payload; a bad
// checksum or a length above 64 drops the packet without output. while the
// framing runs, one byte is accepted every cycle. after a good checksum the
// payload is read back from the 64-entry payload ram through its registered
// read port, one result per cycle while rsp_tready is high, and req_tready
// stays low until every result has reached the output register. the output
// register lets the next packet be framed while the last result still waits.
// the payload ram needs no clearing pass after reset.
module packet_deframer_add_checksum_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // rx_byte[7:0]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [pdac_pkg::BYTE_W-1:0]           req_tdata,
   // packet_cmd[7:0], packet_type[15:8], packet_len[22:16], data_byte[30:23],
   // byte_index[36:31], zero fill[39:37]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [pdac_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // has_data[0]
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast,
   // configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [pdac_pkg::CSR_AW-1:0]           csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import pdac_pkg::*;

   logic [BYTE_W-1:0] start_byte_ff, start_byte_in;
   logic              csr_wr;
   pdac_cmd_type      cmd;
   pdac_status_type   status;

   // register file: only the start byte lives here
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      start_byte_in = start_byte_ff;
      if (csr_wr && (csr_paddr[CSR_AW-1:2] == REG_START_BYTE)) begin
         start_byte_in = csr_pwdata[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
      end else begin
         start_byte_ff <= start_byte_in;
      end
   end

   // reads outside the register list return zero
   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == REG_START_BYTE) ?
                       {{(32 - BYTE_W){1'b0}}, start_byte_ff} : '0;

   // framing controller
   pdac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // header holds, sum, payload ram and result register
   pdac_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .rx_byte    (req_tdata),
      .start_byte (start_byte_ff),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // no input transaction is taken while the payload is being replayed
   a_no_input_in_dump : assert property (@(posedge clock) disable iff (reset)
      (cmd.dump_en || cmd.hdr_load) |-> !req_tready)
      else $error("input accepted during packet output");

   // a header-only result is the single, last one of an empty packet
   a_header_only : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
         (rsp_tlast && (rsp_tdata[22:16] == '0) && (rsp_tdata[36:23] == '0)))
      else $error("malformed header-only result");

   // tlast on a payload result marks exactly the final byte index
   a_last_index : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tlast == (({1'b0, rsp_tdata[36:31]} + 7'd1) == rsp_tdata[22:16])))
      else $error("tlast does not match payload length");

endmodule

// ----- verif/tb_packet_deframer_add_checksum_core.sv -----
// self-checking testbench for the start-byte framed packet receiver with additive checksum
module tb_packet_deframer_add_checksum_core;
   import pdac_pkg::*;

   localparam int HALF_PERIOD        = 6;
   localparam int RESET_CYCLES       = 12;
   // long receiver hold-off, enough for the block to fill up and stall its input
   localparam int HOLD_OFF_CYCLES    = 200;
   // quiet cycles after the last result before a register write
   localparam int SETTLE_CYCLES      = 16;
   // a full payload dump plus margin at the very end
   localparam int DRAIN_CYCLES       = MAX_PAYLOAD + 8;
   // cycles without any transaction before the run is declared hung
   localparam int WATCHDOG_LIMIT     = 2000;
   localparam int RANDOM_PHASE_ITEMS = 4;

   // byte addresses of the configuration port, register i at 4*i
   localparam logic [CSR_AW-1:0] START_ADDR = {REG_START_BYTE, 2'b00};
   localparam logic [CSR_AW-1:0] SPARE_ADDR = START_ADDR + 3'd4;

   // framing phases of the predictor
   typedef enum logic [2:0] {
      SEEK_START,
      GET_CMD,
      GET_TYPE,
      GET_LEN,
      GET_PAYLOAD,
      GET_SUM
   } frame_phase_type;

   // one result transaction as it should appear on rsp_
   typedef struct {
      logic [BYTE_W-1:0] cmd;
      logic [BYTE_W-1:0] ptype;
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] data;
      logic [IDX_W-1:0]  index;
      logic              has_data;
      logic              last;
   } frame_rsp_type;

   // dut ports, all inputs driven to known values from time zero
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]     csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // predictor state: its own copy of the framing fsm, the checksum and the payload
   frame_phase_type       rx_phase   = SEEK_START;
   logic [BYTE_W-1:0]     start_code = START_BYTE_RESET;
   logic [BYTE_W-1:0]     sum_acc    = '0;
   logic [BYTE_W-1:0]     cmd_seen   = '0;
   logic [BYTE_W-1:0]     type_seen  = '0;
   logic [BYTE_W-1:0]     len_seen   = '0;
   int unsigned           fill_count = 0;
   logic [BYTE_W-1:0]     payload_mem [MAX_PAYLOAD];

   // results still owed by the dut, oldest first
   frame_rsp_type         expected_rsp [$];
   frame_rsp_type         exp_rsp;

   // payload of the next frame built by a test
   logic [BYTE_W-1:0]     payload_buf [$];

   // run bookkeeping
   int                    mismatches     = 0;
   int                    items_sent     = 0;
   int                    results_seen   = 0;
   int                    frames_good    = 0;
   int                    frames_dropped = 0;
   int                    idle_cycles    = 0;

   // random idling of both sides, and the receiver hold-off request
   bit                    idle_on       = 1'b0;
   bit                    hold_off_req  = 1'b0;
   int                    hold_off_left = 0;
   int                    burst_left    = 0;

   always #(HALF_PERIOD) clock = ~clock;

   packet_deframer_add_checksum_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // advance the framing model by one received byte and queue any results it releases
   function void deframe_byte(input logic [BYTE_W-1:0] b);
      frame_rsp_type r;
      case (rx_phase)
         SEEK_START: begin
            if (b == start_code) begin
               sum_acc  = '0;
               rx_phase = GET_CMD;
            end
         end
         GET_CMD: begin
            cmd_seen = b;
            sum_acc += b;
            rx_phase = GET_TYPE;
         end
         GET_TYPE: begin
            type_seen = b;
            sum_acc  += b;
            rx_phase  = GET_LEN;
         end
         GET_LEN: begin
            len_seen   = b;
            sum_acc   += b;
            fill_count = 0;
            // a length beyond the payload ram abandons the packet
            if (b > MAX_PAYLOAD) begin
               rx_phase = SEEK_START;
               frames_dropped++;
            end else if (b != 0) begin
               rx_phase = GET_PAYLOAD;
            end else begin
               rx_phase = GET_SUM;
            end
         end
         GET_PAYLOAD: begin
            payload_mem[fill_count] = b;
            fill_count++;
            sum_acc += b;
            if (fill_count >= len_seen) rx_phase = GET_SUM;
         end
         GET_SUM: begin
            // the checksum byte is never taken as a new start byte
            rx_phase = SEEK_START;
            if (b != sum_acc) begin
               frames_dropped++;
            end else begin
               frames_good++;
               r.cmd   = cmd_seen;
               r.ptype = type_seen;
               r.len   = len_seen[LEN_W-1:0];
               if (len_seen == 0) begin
                  // empty payload: one header-only transaction
                  r.data     = '0;
                  r.index    = '0;
                  r.has_data = 1'b0;
                  r.last     = 1'b1;
                  expected_rsp.push_back(r);
               end else begin
                  for (int i = 0; i < len_seen; i++) begin
                     r.data     = payload_mem[i];
                     r.index    = IDX_W'(i);
                     r.has_data = 1'b1;
                     r.last     = (i == len_seen - 1);
                     expected_rsp.push_back(r);
                  end
               end
            end
         end
         default: rx_phase = SEEK_START;
      endcase
   endfunction

   function void check_field(input string name, input logic [BYTE_W-1:0] exp_v,
                             input logic [BYTE_W-1:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   // result checker: every accepted rsp_ transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_rsp.size() == 0) begin
            $error("result transaction with none expected: tdata 0x%0h", rsp_tdata);
            mismatches++;
         end else begin
            exp_rsp = expected_rsp.pop_front();
            // tdata: cmd[7:0] type[15:8] len[22:16] data[30:23] index[36:31]
            check_field("packet_cmd",  exp_rsp.cmd,   rsp_tdata[7:0]);
            check_field("packet_type", exp_rsp.ptype, rsp_tdata[15:8]);
            check_field("packet_len",  BYTE_W'(exp_rsp.len), BYTE_W'(rsp_tdata[22:16]));
            check_field("data_byte",   exp_rsp.data,  rsp_tdata[30:23]);
            check_field("byte_index",  BYTE_W'(exp_rsp.index), BYTE_W'(rsp_tdata[36:31]));
            check_field("has_data",    BYTE_W'(exp_rsp.has_data), BYTE_W'(rsp_tuser));
            check_field("last",        BYTE_W'(exp_rsp.last), BYTE_W'(rsp_tlast));
         end
      end
   end

   // receiver: a long hold-off on request, else random stall bursts while idle_on is set
   always @(posedge clock) begin
      if (hold_off_req) begin
         hold_off_req  = 1'b0;
         hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_tready <= 1'b0;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         burst_left = $urandom_range(1, 5) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: too long without any transaction on any port means the block hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles with no transaction", idle_cycles);
         $display("Verification failed");
         $finish;
      end
   end

   // offer one byte on req_, with an optional random gap first, until it is taken
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      deframe_byte(b);
      items_sent++;
   endtask

   // full frame around payload_buf; a bad checksum uses the start byte where it can
   task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] ptype,
                             input bit bad_sum);
      logic [BYTE_W-1:0] sum;
      sum = cmd + ptype + BYTE_W'(payload_buf.size());
      send_byte(start_code);
      send_byte(cmd);
      send_byte(ptype);
      send_byte(BYTE_W'(payload_buf.size()));
      foreach (payload_buf[i]) begin
         send_byte(payload_buf[i]);
         sum += payload_buf[i];
      end
      if (!bad_sum) send_byte(sum);
      else if (sum != start_code) send_byte(start_code);
      else send_byte(~sum);
   endtask

   task automatic fill_payload(input int n);
      payload_buf.delete();
      repeat (n) payload_buf.push_back(BYTE_W'($urandom));
   endtask

   // header with a length above the ram depth, the packet is abandoned there
   task automatic send_oversize(input logic [BYTE_W-1:0] len);
      send_byte(start_code);
      send_byte(BYTE_W'($urandom));
      send_byte(BYTE_W'($urandom));
      send_byte(len);
   endtask

   // stop offering, wait for every owed result, then let the block settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write or read; a read of the start byte register is checked
   task automatic csr_access(input bit is_write, input logic [CSR_AW-1:0] addr,
                             input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (is_write) begin
         // only register 0 exists, other addresses are ignored
         if (addr == START_ADDR) start_code = value[BYTE_W-1:0];
      end else if (addr == START_ADDR) begin
         check_field("start_byte", start_code, csr_prdata[BYTE_W-1:0]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // idle the bus before the next access
      @(posedge clock);
   endtask

   // field extremes, empty payload, start byte inside a packet, bad checksum, oversize
   task automatic test_directed_frames();
      idle_on = 1'b0;
      // noise while hunting
      send_byte(8'h00);
      send_byte(8'hFF);
      // empty payload, header-only result
      fill_payload(0);
      send_frame(8'hFF, 8'h00, 1'b0);
      // payload holding the start byte and both data extremes
      payload_buf.delete();
      payload_buf.push_back(START_BYTE_RESET);
      payload_buf.push_back(8'h00);
      payload_buf.push_back(8'hFF);
      send_frame(8'h00, 8'hFF, 1'b0);
      // bad checksum equal to the start byte, must not reopen a packet
      payload_buf.delete();
      payload_buf.push_back(8'h03);
      send_frame(8'h01, 8'h02, 1'b1);
      // one past the ram depth
      send_oversize(BYTE_W'(MAX_PAYLOAD + 1));
   endtask

   // start byte at both extremes, read back, and a write to an unused address
   task automatic test_start_byte_config();
      wait_drained();
      csr_access(1'b0, START_ADDR, '0);
      csr_access(1'b1, START_ADDR, {24'($urandom), 8'h00});
      csr_access(1'b0, START_ADDR, '0);
      fill_payload(1);
      send_frame(8'h5A, 8'hA5, 1'b0);
      fill_payload(0);
      send_frame(8'h00, 8'h00, 1'b0);
      wait_drained();
      csr_access(1'b1, START_ADDR, {24'($urandom), 8'hFF});
      fill_payload(1);
      send_frame(BYTE_W'($urandom), BYTE_W'($urandom), 1'b0);
      wait_drained();
      csr_access(1'b1, SPARE_ADDR, $urandom);
      csr_access(1'b0, START_ADDR, '0);
      fill_payload(1);
      send_frame(BYTE_W'($urandom), BYTE_W'($urandom), 1'b0);
   endtask

   // mostly good frames with random content, some noise, bad sums and oversize lengths
   task automatic test_random_traffic();
      int base;
      int kind;
      idle_on = 1'b1;
      for (int ph = 0; ph < 3; ph++) begin
         wait_drained();
         csr_access(1'b1, START_ADDR, $urandom);
         base = items_sent;
         // one packet at the full ram depth
         if (ph == 1) begin
            fill_payload(MAX_PAYLOAD);
            send_frame(BYTE_W'($urandom), BYTE_W'($urandom), 1'b0);
         end
         while (items_sent - base < RANDOM_PHASE_ITEMS) begin
            kind = $urandom_range(0, 15);
            if (kind == 0) begin
               repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom));
            end else if (kind == 1) begin
               send_oversize(BYTE_W'($urandom_range(MAX_PAYLOAD + 1, 255)));
            end else begin
               fill_payload(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8));
               send_frame(BYTE_W'($urandom), BYTE_W'($urandom), kind == 2);
            end
         end
      end
   endtask

   // receiver holds off while frames keep coming, then the sender waits for all results
   task automatic test_output_backpressure();
      idle_on      = 1'b0;
      hold_off_req = 1'b1;
      repeat (2) begin
         fill_payload(2);
         send_frame(BYTE_W'($urandom), BYTE_W'($urandom), 1'b0);
      end
      wait_drained();
   endtask

   // closing stretch at full rate on both sides, back to the reset start byte
   task automatic test_streaming_finish();
      idle_on = 1'b0;
      csr_access(1'b1, START_ADDR, {24'h000000, START_BYTE_RESET});
      repeat (2) begin
         fill_payload($urandom_range(0, 3));
         send_frame(BYTE_W'($urandom), BYTE_W'($urandom), 1'b0);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_start_byte_config();
      test_random_traffic();
      test_output_backpressure();
      test_streaming_finish();
      // all stimulus taken: wait out the owed results and any stray output
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d byte transactions in and %0d result transactions out",
               items_sent, results_seen);
      $display("%0d packets passed the checksum, %0d dropped on a bad checksum or length",
               frames_good, frames_dropped);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
